@@ hdl/render_command_dependency_tracker_defines.svh @@
// assertion macros for the render command dependency tracker
// used by rtl files that carry concurrent checks, needs nothing else
`ifndef RENDER_COMMAND_DEPENDENCY_TRACKER_DEFINES_SVH
`define RENDER_COMMAND_DEPENDENCY_TRACKER_DEFINES_SVH

// implication checked at every rising edge outside reset
`define RCDT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define RCDT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/rcdt_pkg.sv @@
// shared types and constants of the render command dependency tracker
// no dependencies
`default_nettype none

package rcdt_pkg;

  localparam int MAX_NODES = 1024;
  localparam int TEX_SLOTS = 16;
  localparam int IDX_W     = $clog2(MAX_NODES + 1);
  localparam int EDGE_W    = 10;
  localparam int SLOT_W    = 4;
  localparam int TEX_W     = (TEX_SLOTS > 1) ? $clog2(TEX_SLOTS) : 1;
  localparam int TRACK_N   = 4 + TEX_SLOTS;
  localparam int POS_W     = $clog2(TRACK_N);

  localparam int IN_DATA_W  = 8;
  localparam int IN_USER_W  = 6;
  localparam int OUT_DATA_W = 24;

  // tracker positions in scan order
  localparam logic [POS_W-1:0] TRK_SHADER = POS_W'(0);
  localparam logic [POS_W-1:0] TRK_FRAME  = POS_W'(1);
  localparam logic [POS_W-1:0] TRK_VERTEX = POS_W'(2);
  localparam logic [POS_W-1:0] TRK_INDEX  = POS_W'(3);
  localparam logic [POS_W-1:0] TRK_TEX0   = POS_W'(4);

  localparam logic [IDX_W-1:0] OWNER_NONE = '1;

  typedef enum logic [2:0] {
    KIND_SHADER  = 3'd0,
    KIND_UNIFORM = 3'd1,
    KIND_BIND    = 3'd2,
    KIND_COLOR   = 3'd3,
    KIND_DEPTH   = 3'd4,
    KIND_DRAW    = 3'd5,
    KIND_OTHER   = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    RES_FRAME   = 3'd0,
    RES_VERTEX  = 3'd1,
    RES_INDEX   = 3'd2,
    RES_TEXTURE = 3'd3,
    RES_OTHER   = 3'd4
  } res_kind_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

endpackage

`default_nettype wire

@@ hdl/render_command_dependency_tracker.sv @@
// latency: a command with no edge to emit finishes in the accepting cycle, ready stays high
// uniform, colour, depth and draw scan the trackers in order, one tracker per cycle, and the
// scan stops after the highest tracker that gives an edge
// each edge leaves through the output register, a stalled output holds the scan
// throughput: one command per cycle without edges, no new command is taken while a scan runs
// reset: synchronous active-low rst_n clears numbering, all trackers and the output
`default_nettype none
`include "render_command_dependency_tracker_defines.svh"

module render_command_dependency_tracker (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [rcdt_pkg::IN_DATA_W-1:0]     in_tdata,   // slot[3:0], zero fill
  input  wire logic [rcdt_pkg::IN_USER_W-1:0]     in_tuser,   // kind[2:0], resource_kind[5:3]
  input  wire logic                               in_tlast,   // last_command
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [rcdt_pkg::OUT_DATA_W-1:0]         out_tdata,  // edge_src[9:0], edge_dst[19:10]
  output logic                                    out_tlast   // last_edge
);
  import rcdt_pkg::*;

  // sequencer
  state_t               state_r, state_nxt;
  logic [TRACK_N-1:0]   mask_r, mask_nxt;     // trackers still to visit that give an edge
  logic [POS_W-1:0]     pos_r, pos_nxt;       // tracker under the shared select
  logic [IDX_W-1:0]     cur_r, cur_nxt;       // number of the command being scanned
  logic                 last_r, last_nxt;     // clear trackers once the scan ends

  // command numbering and owner trackers
  logic [IDX_W-1:0]     cmd_idx_r, cmd_idx_nxt;
  logic [IDX_W-1:0]     shader_r, shader_nxt;
  logic [IDX_W-1:0]     frame_r, frame_nxt;
  logic [IDX_W-1:0]     vertex_r, vertex_nxt;
  logic [IDX_W-1:0]     index_r, index_nxt;
  logic [IDX_W-1:0]     tex_r   [TEX_SLOTS];
  logic [IDX_W-1:0]     tex_nxt [TEX_SLOTS];

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 in_acc;
  logic                 out_free;
  logic [TRACK_N-1:0]   set_vec;      // tracker holds an in-range owner
  logic [TRACK_N-1:0]   new_mask;
  logic [TRACK_N-1:0]   mask_rest;
  logic [IDX_W-1:0]     sel_owner;
  logic [TEX_W-1:0]     tex_sel;
  logic [POS_W-1:0]     tex_pos;
  logic                 emit;
  logic                 step;
  kind_t                in_kind;
  res_kind_t            in_res;
  logic [SLOT_W-1:0]    in_slot;

  assign in_kind  = kind_t'(in_tuser[2:0]);
  assign in_res   = res_kind_t'(in_tuser[5:3]);
  assign in_slot  = in_tdata[SLOT_W-1:0];

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // which trackers hold an owner that can source an edge
  always_comb begin
    set_vec[TRK_SHADER] = (shader_r < IDX_W'(MAX_NODES));
    set_vec[TRK_FRAME]  = (frame_r  < IDX_W'(MAX_NODES));
    set_vec[TRK_VERTEX] = (vertex_r < IDX_W'(MAX_NODES));
    set_vec[TRK_INDEX]  = (index_r  < IDX_W'(MAX_NODES));
    for (int t = 0; t < TEX_SLOTS; t++) begin
      set_vec[4 + t] = (tex_r[t] < IDX_W'(MAX_NODES));
    end
  end

  // trackers that the incoming command depends on
  always_comb begin
    new_mask = '0;
    unique case (in_kind)
      KIND_UNIFORM: new_mask[TRK_SHADER] = set_vec[TRK_SHADER];
      KIND_COLOR,
      KIND_DEPTH:   new_mask[TRK_FRAME] = set_vec[TRK_FRAME];
      KIND_DRAW:    new_mask = set_vec;
      default:      new_mask = '0;
    endcase
    // destination out of range gives no edge at all
    if (cmd_idx_r >= IDX_W'(MAX_NODES)) begin
      new_mask = '0;
    end
  end

  // shared tracker select for the scan position
  assign tex_pos = pos_r - TRK_TEX0;
  assign tex_sel = tex_pos[TEX_W-1:0];

  always_comb begin
    priority if (pos_r == TRK_SHADER) begin
      sel_owner = shader_r;
    end else if (pos_r == TRK_FRAME) begin
      sel_owner = frame_r;
    end else if (pos_r == TRK_VERTEX) begin
      sel_owner = vertex_r;
    end else if (pos_r == TRK_INDEX) begin
      sel_owner = index_r;
    end else begin
      sel_owner = tex_r[tex_sel];
    end
  end

  assign mask_rest = mask_r >> 1;
  assign emit      = (state_r == ST_SCAN) && mask_r[0] && out_free;
  assign step      = (state_r == ST_SCAN) && (!mask_r[0] || out_free);

  // next state and datapath
  always_comb begin
    state_nxt     = state_r;
    mask_nxt      = mask_r;
    pos_nxt       = pos_r;
    cur_nxt       = cur_r;
    last_nxt      = last_r;
    cmd_idx_nxt   = cmd_idx_r;
    shader_nxt    = shader_r;
    frame_nxt     = frame_r;
    vertex_nxt    = vertex_r;
    index_nxt     = index_r;
    tex_nxt       = tex_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cur_nxt  = cmd_idx_r;
          last_nxt = in_tlast;
          mask_nxt = new_mask;
          pos_nxt  = '0;
          if (cmd_idx_r < IDX_W'(MAX_NODES)) begin
            cmd_idx_nxt = cmd_idx_r + IDX_W'(1);
          end
          // owner updates come only from commands that emit nothing
          if (in_kind == KIND_SHADER) begin
            shader_nxt = cmd_idx_r;
          end else if (in_kind == KIND_BIND) begin
            priority case (in_res)
              RES_FRAME:   frame_nxt  = cmd_idx_r;
              RES_VERTEX:  vertex_nxt = cmd_idx_r;
              RES_INDEX:   index_nxt  = cmd_idx_r;
              RES_TEXTURE: begin
                if ({1'b0, in_slot} < (SLOT_W + 1)'(TEX_SLOTS)) begin
                  tex_nxt[in_slot[TEX_W-1:0]] = cmd_idx_r;
                end
              end
              default: ;
            endcase
          end
          if (new_mask != '0) begin
            state_nxt = ST_SCAN;
          end else if (in_tlast) begin
            cmd_idx_nxt = '0;
            shader_nxt  = OWNER_NONE;
            frame_nxt   = OWNER_NONE;
            vertex_nxt  = OWNER_NONE;
            index_nxt   = OWNER_NONE;
            for (int t = 0; t < TEX_SLOTS; t++) begin
              tex_nxt[t] = OWNER_NONE;
            end
          end
        end
      end
      ST_SCAN: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {(OUT_DATA_W - 2 * EDGE_W)'(0),
                           cur_r[EDGE_W-1:0], sel_owner[EDGE_W-1:0]};
          out_last_nxt  = (mask_rest == '0);
        end
        if (step) begin
          mask_nxt = mask_rest;
          pos_nxt  = pos_r + POS_W'(1);
          if (mask_rest == '0) begin
            state_nxt = ST_IDLE;
            if (last_r) begin
              cmd_idx_nxt = '0;
              shader_nxt  = OWNER_NONE;
              frame_nxt   = OWNER_NONE;
              vertex_nxt  = OWNER_NONE;
              index_nxt   = OWNER_NONE;
              for (int t = 0; t < TEX_SLOTS; t++) begin
                tex_nxt[t] = OWNER_NONE;
              end
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mask_r      <= '0;
      pos_r       <= '0;
      cmd_idx_r   <= '0;
      shader_r    <= OWNER_NONE;
      frame_r     <= OWNER_NONE;
      vertex_r    <= OWNER_NONE;
      index_r     <= OWNER_NONE;
      for (int t = 0; t < TEX_SLOTS; t++) begin
        tex_r[t] <= OWNER_NONE;
      end
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mask_r      <= mask_nxt;
      pos_r       <= pos_nxt;
      cmd_idx_r   <= cmd_idx_nxt;
      shader_r    <= shader_nxt;
      frame_r     <= frame_nxt;
      vertex_r    <= vertex_nxt;
      index_r     <= index_nxt;
      tex_r       <= tex_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  // a scan is only entered with work pending
  `RCDT_ASSERT_IMP(a_scan_has_work, state_r == ST_SCAN, mask_r != '0,
    "scan running with no tracker left")
  // the final edge of a command ends its scan
  `RCDT_ASSERT_NEXT(a_last_edge_ends_scan, emit && out_last_nxt, state_r == ST_IDLE,
    "scan continued after final edge")
  // numbering holds still while a scan continues
  `RCDT_ASSERT_NEXT(a_index_stable, state_r == ST_SCAN && state_nxt == ST_SCAN,
    $stable(cmd_idx_r), "command number moved during scan")
  // scan position never runs past the trackers
  `RCDT_ASSERT_IMP(a_pos_range, state_r == ST_SCAN, pos_r < POS_W'(TRACK_N),
    "scan position beyond last tracker")

endmodule

`default_nettype wire

@@ sim/render_command_dependency_tracker_test.sv @@
// self-checking testbench for render_command_dependency_tracker
// drives command transfers, predicts the dependency edges and compares each edge transfer
// depends on rcdt_pkg and the rtl top level only
module render_command_dependency_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rcdt_pkg::*;

  // kind and bind target codes that the package leaves unnamed
  localparam logic [2:0] KIND_RESERVED = 3'd7;
  localparam logic [2:0] RES_RESERVED  = 3'd7;

  localparam int RANDOM_ITEMS = 210;
  localparam int HOLD_AFTER   = 60;     // commands taken before the long output hold
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;     // idle wait once nothing is pending
  localparam int ERR_PRINT    = 40;

  typedef struct packed {
    kind_t             kind;
    res_kind_t         res;
    logic [SLOT_W-1:0] slot;
    logic              last;
    logic [3:0]        gap;     // idle cycles before this command is offered
  } command_t;

  typedef struct packed {
    logic [EDGE_W-1:0] src;
    logic [EDGE_W-1:0] dst;
    logic              last;
  } dep_edge_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  render_command_dependency_tracker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // pending commands, the one on the bus, and edges still owed by the block
  command_t  cmd_queue[$];
  command_t  offered;
  dep_edge_t edges_due[$];

  // predictor state: command numbering and the latest owner of each resource
  logic [IDX_W-1:0] cmd_no;
  logic [IDX_W-1:0] shader_at;
  logic [IDX_W-1:0] frame_at;
  logic [IDX_W-1:0] vertex_at;
  logic [IDX_W-1:0] index_at;
  logic [IDX_W-1:0] texture_at [TEX_SLOTS];
  dep_edge_t        held_edge;
  logic             edge_held;

  int   err_count;
  int   cmds_queued;
  int   cmds_taken;
  int   edges_taken;
  int   send_wait;
  int   rx_wait;
  int   hold_left;
  logic hold_done;
  logic in_took;
  logic out_took;
  logic tx_calm;
  logic rx_calm;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= ERR_PRINT) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // dependency predictor
  // --------------------------------------------------------------------------

  task automatic clear_owners();
    cmd_no    = '0;
    shader_at = OWNER_NONE;
    frame_at  = OWNER_NONE;
    vertex_at = OWNER_NONE;
    index_at  = OWNER_NONE;
    for (int t = 0; t < TEX_SLOTS; t++) texture_at[t] = OWNER_NONE;
  endtask

  // the not-set marker lies above MAX_NODES as well, so one range test covers both;
  // the newest edge is held back so that the final one of a command can be flagged
  task automatic add_edge(input logic [IDX_W-1:0] src, input logic [IDX_W-1:0] dst);
    if (src < MAX_NODES && dst < MAX_NODES) begin
      if (edge_held) edges_due.push_back(held_edge);
      held_edge.src  = src[EDGE_W-1:0];
      held_edge.dst  = dst[EDGE_W-1:0];
      held_edge.last = 1'b0;
      edge_held      = 1'b1;
    end
  endtask

  task automatic predict_edges(input command_t c);
    case (c.kind)
      KIND_SHADER: shader_at = cmd_no;
      KIND_UNIFORM: add_edge(shader_at, cmd_no);
      KIND_BIND: begin
        case (c.res)
          RES_FRAME:   frame_at  = cmd_no;
          RES_VERTEX:  vertex_at = cmd_no;
          RES_INDEX:   index_at  = cmd_no;
          RES_TEXTURE: if (c.slot < TEX_SLOTS) texture_at[c.slot] = cmd_no;
          default: ;   // unknown target: numbered, nothing changes
        endcase
      end
      KIND_COLOR, KIND_DEPTH: add_edge(frame_at, cmd_no);
      KIND_DRAW: begin
        add_edge(shader_at, cmd_no);
        add_edge(frame_at, cmd_no);
        add_edge(vertex_at, cmd_no);
        add_edge(index_at, cmd_no);
        for (int t = 0; t < TEX_SLOTS; t++) add_edge(texture_at[t], cmd_no);
      end
      default: ;       // other and reserved kinds are only numbered
    endcase
    if (edge_held) begin
      held_edge.last = 1'b1;
      edges_due.push_back(held_edge);
      edge_held = 1'b0;
    end
    // numbering saturates at MAX_NODES, which is already out of range
    if (cmd_no < MAX_NODES) cmd_no = cmd_no + 1'b1;
    if (c.last) clear_owners();
  endtask

  // --------------------------------------------------------------------------
  // stimulus builders
  // --------------------------------------------------------------------------

  task automatic push_cmd(input logic [2:0] kind, input logic [2:0] res,
                          input int slot, input logic last);
    command_t c;
    // sender switches between calm and gappy stretches every thirty commands
    if (cmds_queued % 30 == 0) tx_calm = ($urandom_range(0, 3) == 0);
    c.kind = kind_t'(kind);
    c.res  = res_kind_t'(res);
    c.slot = SLOT_W'(slot);
    c.last = last;
    c.gap  = tx_calm ? 4'd0 : 4'($urandom_range(0, 10));
    cmd_queue.push_back(c);
    cmds_queued++;
  endtask

  task automatic push_random_cmd(input logic last);
    int   roll;
    logic [2:0] kind;
    logic [2:0] res;
    roll = $urandom_range(0, 99);
    if (roll < 12)      kind = KIND_SHADER;
    else if (roll < 22) kind = KIND_UNIFORM;
    else if (roll < 52) kind = KIND_BIND;
    else if (roll < 60) kind = KIND_COLOR;
    else if (roll < 66) kind = KIND_DEPTH;
    else if (roll < 92) kind = KIND_DRAW;
    else if (roll < 96) kind = KIND_OTHER;
    else                kind = KIND_RESERVED;
    // mostly real bind targets, now and then an unknown one
    if ($urandom_range(0, 99) < 85) res = 3'($urandom_range(RES_FRAME, RES_TEXTURE));
    else                            res = 3'($urandom_range(RES_OTHER, RES_RESERVED));
    push_cmd(kind, res, $urandom_range(0, TEX_SLOTS - 1), last);
  endtask

  // one command list ending in the last-command flag
  task automatic push_random_list();
    int len;
    if ($urandom_range(0, 99) < 12) begin
      // every tracker set, then draws that scan all twenty of them
      push_cmd(KIND_SHADER, RES_FRAME, 0, 1'b0);
      push_cmd(KIND_BIND, RES_FRAME, 0, 1'b0);
      push_cmd(KIND_BIND, RES_VERTEX, 0, 1'b0);
      push_cmd(KIND_BIND, RES_INDEX, 0, 1'b0);
      for (int t = 0; t < TEX_SLOTS; t++) push_cmd(KIND_BIND, RES_TEXTURE, t, 1'b0);
      push_cmd(KIND_DRAW, RES_FRAME, 0, 1'b0);
      push_random_cmd(1'b0);
      push_cmd(KIND_DRAW, RES_FRAME, 0, 1'b1);
    end else begin
      len = $urandom_range(2, 14);
      for (int i = 0; i < len; i++)
        push_random_cmd((i == len - 1) || ($urandom_range(0, 99) < 3));
    end
  endtask

  // a list long enough to run the numbering into saturation
  task automatic push_long_list();
    logic [2:0] kind;
    for (int i = 0; i < 1016; i++) begin
      case ($urandom_range(0, 7))
        0, 1:    kind = KIND_SHADER;
        2, 3, 4: kind = KIND_BIND;
        5:       kind = KIND_OTHER;
        6:       kind = KIND_RESERVED;
        default: kind = ($urandom_range(0, 1) != 0) ? KIND_UNIFORM : KIND_COLOR;
      endcase
      push_cmd(kind, 3'($urandom_range(0, 7)), $urandom_range(0, TEX_SLOTS - 1), 1'b0);
    end
    push_cmd(KIND_BIND, RES_FRAME, 0, 1'b0);        // command 1016
    push_cmd(KIND_BIND, RES_VERTEX, 0, 1'b0);
    push_cmd(KIND_BIND, RES_INDEX, 0, 1'b0);
    push_cmd(KIND_BIND, RES_TEXTURE, 15, 1'b0);
    push_cmd(KIND_SHADER, RES_FRAME, 0, 1'b0);      // command 1020
    push_cmd(KIND_UNIFORM, RES_FRAME, 0, 1'b0);
    push_cmd(KIND_DRAW, RES_FRAME, 0, 1'b0);
    push_cmd(KIND_DRAW, RES_FRAME, 0, 1'b0);        // highest destination number
    push_cmd(KIND_DRAW, RES_FRAME, 0, 1'b0);        // saturated: no edges
    push_cmd(KIND_BIND, RES_FRAME, 0, 1'b0);        // owner number out of range
    push_cmd(KIND_COLOR, RES_FRAME, 0, 1'b0);
    push_cmd(KIND_SHADER, RES_FRAME, 0, 1'b0);
    push_cmd(KIND_UNIFORM, RES_FRAME, 0, 1'b0);
    push_cmd(KIND_DRAW, RES_FRAME, 0, 1'b1);
    // numbering must restart at zero
    push_cmd(KIND_SHADER, RES_FRAME, 0, 1'b0);
    push_cmd(KIND_UNIFORM, RES_FRAME, 0, 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // input driver: offers commands at the falling edge, honours each one's gap
  // --------------------------------------------------------------------------

  always @(negedge clk) begin
    logic offer;
    if (rst_n) begin
      offer = in_tvalid;
      if (in_tvalid && in_took) begin
        offer = 1'b0;
        if (cmd_queue.size() != 0) send_wait = cmd_queue[0].gap;
      end
      if (!offer && cmd_queue.size() != 0) begin
        if (send_wait != 0) begin
          send_wait--;
        end else begin
          offered  = cmd_queue.pop_front();
          in_tdata <= IN_DATA_W'(offered.slot);
          in_tuser <= IN_USER_W'({offered.res, offered.kind});
          in_tlast <= offered.last;
          offer    = 1'b1;
        end
      end
      in_tvalid <= offer;
    end
  end

  // --------------------------------------------------------------------------
  // output side: random stalls per edge, calm stretches, one long hold
  // --------------------------------------------------------------------------

  // long hold so that draws back up and the block stops taking commands
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && cmds_taken >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_took) begin
        if (edges_taken % 50 == 0) rx_calm = ($urandom_range(0, 3) == 0);
        rx_wait = rx_calm ? 0 : $urandom_range(0, 10);
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
      end else if (rx_wait != 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: both transfers sampled at the rising edge
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    dep_edge_t want;
    in_took  <= rst_n && in_tvalid && in_tready;
    out_took <= rst_n && out_tvalid && out_tready;
    if (rst_n) begin
      // the output is registered, so an edge never stems from this cycle's command
      if (out_tvalid && out_tready) begin
        edges_taken <= edges_taken + 1;
        if (edges_due.size() == 0) begin
          report_mismatch($sformatf("edge %0d -> %0d with nothing expected",
                                    out_tdata[EDGE_W-1:0], out_tdata[2*EDGE_W-1:EDGE_W]));
        end else begin
          want = edges_due.pop_front();
          if (out_tdata[EDGE_W-1:0] !== want.src)
            report_mismatch($sformatf("edge_src %0d, expected %0d",
                                      out_tdata[EDGE_W-1:0], want.src));
          if (out_tdata[2*EDGE_W-1:EDGE_W] !== want.dst)
            report_mismatch($sformatf("edge_dst %0d, expected %0d",
                                      out_tdata[2*EDGE_W-1:EDGE_W], want.dst));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("last_edge %0b, expected %0b on %0d -> %0d",
                                      out_tlast, want.last, want.src, want.dst));
        end
      end
      if (in_tvalid && in_tready) begin
        predict_edges(offered);
        cmds_taken <= cmds_taken + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // sequence: reset, directed lists, random lists, saturation list, drain
  // --------------------------------------------------------------------------

  initial begin
    int random_start;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    in_tlast    = 1'b0;
    out_tready  = 1'b0;
    err_count   = 0;
    cmds_queued = 0;
    cmds_taken  = 0;
    edges_taken = 0;
    send_wait   = 0;
    rx_wait     = 0;
    in_took     = 1'b0;
    out_took    = 1'b0;
    tx_calm     = 1'b0;
    rx_calm     = 1'b0;
    edge_held   = 1'b0;
    held_edge   = '0;
    offered     = '0;
    clear_owners();

    // directed: nothing set yet, unknown kinds and targets
    push_cmd(KIND_UNIFORM, RES_FRAME, 0, 1'b0);
    push_cmd(KIND_COLOR, RES_FRAME, 0, 1'b0);
    push_cmd(KIND_DEPTH, RES_FRAME, 0, 1'b0);
    push_cmd(KIND_DRAW, RES_FRAME, 0, 1'b0);
    push_cmd(KIND_OTHER, RES_FRAME, 0, 1'b0);
    push_cmd(KIND_RESERVED, RES_RESERVED, 15, 1'b0);
    push_cmd(KIND_BIND, RES_OTHER, 3, 1'b0);
    push_cmd(KIND_BIND, RES_RESERVED, 15, 1'b0);
    // set the trackers, textures at both ends and in between
    push_cmd(KIND_BIND, RES_FRAME, 0, 1'b0);
    push_cmd(KIND_SHADER, RES_FRAME, 0, 1'b0);
    push_cmd(KIND_BIND, RES_VERTEX, 0, 1'b0);
    push_cmd(KIND_BIND, RES_INDEX, 0, 1'b0);
    push_cmd(KIND_BIND, RES_TEXTURE, 0, 1'b0);
    push_cmd(KIND_BIND, RES_TEXTURE, 15, 1'b0);
    push_cmd(KIND_BIND, RES_TEXTURE, 10, 1'b0);
    push_cmd(KIND_BIND, RES_TEXTURE, 5, 1'b0);
    // each dependent kind once, then a last command that clears everything
    push_cmd(KIND_UNIFORM, RES_FRAME, 0, 1'b0);
    push_cmd(KIND_COLOR, RES_FRAME, 0, 1'b0);
    push_cmd(KIND_DEPTH, RES_FRAME, 0, 1'b0);
    push_cmd(KIND_DRAW, RES_FRAME, 0, 1'b0);
    push_cmd(KIND_SHADER, RES_FRAME, 0, 1'b1);
    push_cmd(KIND_UNIFORM, RES_FRAME, 0, 1'b0);
    push_cmd(KIND_DRAW, RES_FRAME, 0, 1'b1);

    random_start = cmds_queued;
    while (cmds_queued - random_start < RANDOM_ITEMS) push_random_list();
    push_long_list();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmd_queue.size() != 0 || in_tvalid || edges_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (edges_due.size() != 0)
      report_mismatch($sformatf("%0d expected edges never arrived", edges_due.size()));

    if (err_count == 0) begin
      $display("render_command_dependency_tracker verification clean");
    end else begin
      $display("render_command_dependency_tracker verification failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #25000000;
    $display("render_command_dependency_tracker verification failed");
    $finish;
  end

endmodule
